// ===== hw/rtl/wcs_pkg.sv =====
package wcs_pkg;

   localparam int COORD_BITS = 24;
   localparam int RAD_BITS   = 23;
   localparam int WGT_BITS   = 16;
   localparam int GAIN_BITS  = 16;
   localparam int THR_BITS   = 23;

   // radius sum, and every magnitude that matters once the circles are close
   localparam int MAG_W      = RAD_BITS + 1;
   localparam int SQ_W       = 2 * MAG_W + 1;
   localparam int ROOT_W     = SQ_W + 1;
   localparam int SQRT_STEPS = MAG_W + 1;
   localparam int WT_W       = WGT_BITS + 1;
   localparam int F_W        = MAG_W + GAIN_BITS - 8;
   localparam int QB         = F_W + 1;
   localparam int N1_W       = F_W + WGT_BITS + 1;
   localparam int N2_W       = F_W + MAG_W + 1;

   localparam int CSR_W      = THR_BITS;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_PUSH_GAIN       = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_THRESHOLD = 1'b1;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd1280;
   localparam logic [THR_BITS-1:0]  THR_RESET  = 23'd256;

   // front 3, root cells, 3, weight divide, 2, direction divide, output
   localparam int WCS_LATENCY = 3 + SQRT_STEPS + 3 + QB + 2 + QB + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] first_x;
      logic signed [COORD_BITS-1:0] first_y;
      logic [RAD_BITS-1:0]          first_radius;
      logic [WGT_BITS-1:0]          first_weight;
      logic signed [COORD_BITS-1:0] second_x;
      logic signed [COORD_BITS-1:0] second_y;
      logic [RAD_BITS-1:0]          second_radius;
      logic [WGT_BITS-1:0]          second_weight;
   } wcs_req_type;

   typedef struct packed {
      logic                         collided;
      logic                         pushed;
      logic signed [COORD_BITS-1:0] new_first_x;
      logic signed [COORD_BITS-1:0] new_first_y;
      logic signed [COORD_BITS-1:0] new_second_x;
      logic signed [COORD_BITS-1:0] new_second_y;
   } wcs_rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] first_x;
      logic signed [COORD_BITS-1:0] first_y;
      logic signed [COORD_BITS-1:0] second_x;
      logic signed [COORD_BITS-1:0] second_y;
      logic                         neg_x;
      logic                         neg_y;
      logic [MAG_W-1:0]             adx;
      logic [MAG_W-1:0]             ady;
      logic [MAG_W-1:0]             rsum;
      logic [WGT_BITS-1:0]          first_weight;
      logic [WGT_BITS-1:0]          second_weight;
      logic                         near;
      logic                         collided;
      logic                         push;
      logic [MAG_W-1:0]             d;
   } wcs_ctx_type;

endpackage

// ===== hw/rtl/wcs_sqrt_cell.sv =====
module wcs_sqrt_cell #(
   parameter int SQ_W   = 50,
   parameter int SH     = 0,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              vld_i,
   input  logic [SQ_W-1:0]   rem_i,
   input  logic [SQ_W-1:0]   root_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic              vld_o,
   output logic [SQ_W-1:0]   rem_o,
   output logic [SQ_W-1:0]   root_o,
   output logic [SIDE_W-1:0] side_o
);
   localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << SH;

   logic              vld_ff;
   logic [SQ_W-1:0]   rem_ff, rem_in;
   logic [SQ_W-1:0]   root_ff, root_in;
   logic [SIDE_W-1:0] side_ff;
   logic [SQ_W-1:0]   trial;

   always_comb begin
      trial = root_i + BIT;
      if (rem_i >= trial) begin
         rem_in  = rem_i - trial;
         root_in = (root_i >> 1) + BIT;
      end else begin
         rem_in  = rem_i;
         root_in = root_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      side_ff <= side_i;
   end

   assign vld_o  = vld_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign side_o = side_ff;
endmodule

// ===== hw/rtl/wcs_div_cell.sv =====
module wcs_div_cell #(
   parameter int LANES  = 1,
   parameter int NUM_W  = 8,
   parameter int DEN_W  = 4,
   parameter int QB     = 4,
   parameter int K      = 0,
   parameter int SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        vld_i,
   input  logic [LANES-1:0][NUM_W-1:0] num_i,
   input  logic [LANES-1:0][QB-1:0]    quo_i,
   input  logic [DEN_W-1:0]            den_i,
   input  logic [SIDE_W-1:0]           side_i,
   output logic                        vld_o,
   output logic [LANES-1:0][NUM_W-1:0] num_o,
   output logic [LANES-1:0][QB-1:0]    quo_o,
   output logic [DEN_W-1:0]            den_o,
   output logic [SIDE_W-1:0]           side_o
);
   localparam int CW = (DEN_W + K > NUM_W) ? DEN_W + K : NUM_W;

   logic                        vld_ff;
   logic [LANES-1:0][NUM_W-1:0] num_ff, num_in;
   logic [LANES-1:0][QB-1:0]    quo_ff, quo_in;
   logic [DEN_W-1:0]            den_ff;
   logic [SIDE_W-1:0]           side_ff;
   logic [CW-1:0]               den_sh;

   // one restoring step: quotient bit K for every lane against a shared divisor
   always_comb begin
      den_sh = CW'(den_i) << K;
      for (int l = 0; l < LANES; l++) begin
         if (CW'(num_i[l]) >= den_sh) begin
            num_in[l] = NUM_W'(CW'(num_i[l]) - den_sh);
            quo_in[l] = quo_i[l] | (QB'(1) << K);
         end else begin
            num_in[l] = num_i[l];
            quo_in[l] = quo_i[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      den_ff  <= den_i;
      side_ff <= side_i;
   end

   assign vld_o  = vld_ff;
   assign num_o  = num_ff;
   assign quo_o  = quo_ff;
   assign den_o  = den_ff;
   assign side_o = side_ff;
endmodule

// ===== hw/rtl/weighted_circle_separation.sv =====
// Channel   Ports                           Transfer
// request   start, busy, req_data           start high, busy low at clock edge
// result    rsp_strobe, rsp_data            rsp_strobe high for one cycle
// config    csr_we, csr_addr, csr_wdata     csr_we high at clock edge
//
// A new pair is taken every cycle while busy is low. Each pair passes through
// 3 front stages, 25 square root cells, 3 scaling stages, 33 cells
// dividing by total weight, 2 product stages, 33 cells dividing by distance,
// and the output register. busy is high only during reset; reset flushes the
// pipeline and loads the gain and threshold defaults. The receiver cannot stall.
module weighted_circle_separation (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  wcs_pkg::wcs_req_type             req_data,
   output logic                             rsp_strobe,
   output wcs_pkg::wcs_rsp_type             rsp_data,
   input  logic                             csr_we,
   input  logic [wcs_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [wcs_pkg::CSR_W-1:0]        csr_wdata
);
   import wcs_pkg::*;

   localparam int CTX_W = $bits(wcs_ctx_type);
   localparam int DX_W  = COORD_BITS + 1;
   localparam int CMP_W = (DX_W > MAG_W) ? DX_W : MAG_W;
   localparam int PW    = MAG_W + GAIN_BITS;
   localparam int PA_W  = F_W + MAG_W;
   localparam int SW    = ((COORD_BITS > QB) ? COORD_BITS : QB) + 2;
   localparam logic signed [SW-1:0] C_MAX =
      signed'({{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
   localparam logic signed [SW-1:0] C_MIN =
      signed'({{(SW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}});

   function automatic logic signed [COORD_BITS-1:0] sat_move(
      input logic signed [COORD_BITS-1:0] base,
      input logic [QB-1:0]                mag,
      input logic                         neg
   );
      logic signed [SW-1:0] b;
      logic signed [SW-1:0] m;
      logic signed [SW-1:0] s;
      b = SW'(base);
      m = signed'(SW'(mag));
      s = neg ? b - m : b + m;
      if (s > C_MAX) begin
         s = C_MAX;
      end else if (s < C_MIN) begin
         s = C_MIN;
      end
      return s[COORD_BITS-1:0];
   endfunction

   // configuration
   logic [GAIN_BITS-1:0] push_gain_ff;
   logic [THR_BITS-1:0]  depth_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         push_gain_ff       <= GAIN_RESET;
         depth_threshold_ff <= THR_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PUSH_GAIN: begin
               push_gain_ff <= csr_wdata[GAIN_BITS-1:0];
            end
            CSR_DEPTH_THRESHOLD: begin
               depth_threshold_ff <= csr_wdata[THR_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign busy = reset;

   // stage 1: differences, radius sum, coarse box test
   logic              p1_vld_ff;
   wcs_ctx_type       p1_ctx_ff, p1_ctx_in;
   logic signed [DX_W-1:0] dx_s, dy_s;
   logic [DX_W-1:0]   adx_full, ady_full;
   logic [MAG_W-1:0]  rsum_s;

   always_comb begin
      dx_s     = DX_W'(req_data.first_x) - DX_W'(req_data.second_x);
      dy_s     = DX_W'(req_data.first_y) - DX_W'(req_data.second_y);
      adx_full = dx_s[DX_W-1] ? DX_W'(-dx_s) : DX_W'(dx_s);
      ady_full = dy_s[DX_W-1] ? DX_W'(-dy_s) : DX_W'(dy_s);
      rsum_s   = MAG_W'(req_data.first_radius) + MAG_W'(req_data.second_radius);
      p1_ctx_in               = '0;
      p1_ctx_in.first_x       = req_data.first_x;
      p1_ctx_in.first_y       = req_data.first_y;
      p1_ctx_in.second_x      = req_data.second_x;
      p1_ctx_in.second_y      = req_data.second_y;
      p1_ctx_in.neg_x         = dx_s[DX_W-1];
      p1_ctx_in.neg_y         = dy_s[DX_W-1];
      p1_ctx_in.adx           = MAG_W'(adx_full);
      p1_ctx_in.ady           = MAG_W'(ady_full);
      p1_ctx_in.rsum          = rsum_s;
      p1_ctx_in.first_weight  = req_data.first_weight;
      p1_ctx_in.second_weight = req_data.second_weight;
      p1_ctx_in.near          = (CMP_W'(adx_full) < CMP_W'(rsum_s)) &&
                                (CMP_W'(ady_full) < CMP_W'(rsum_s));
   end

   // stage 2: squares
   logic                 p2_vld_ff;
   wcs_ctx_type          p2_ctx_ff;
   logic [2*MAG_W-1:0]   p2_sqx_ff, p2_sqy_ff, p2_rsq_ff;

   // stage 3: sum of squares, exact overlap test
   logic                 p3_vld_ff;
   wcs_ctx_type          p3_ctx_ff, p3_ctx_in;
   logic [SQ_W-1:0]      p3_sq_ff, p3_sq_in;

   always_comb begin
      p3_sq_in           = SQ_W'(p2_sqx_ff) + SQ_W'(p2_sqy_ff);
      p3_ctx_in          = p2_ctx_ff;
      p3_ctx_in.collided = p2_ctx_ff.near && (p3_sq_in < SQ_W'(p2_rsq_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= start && !busy;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ctx_ff <= p1_ctx_in;
      p2_ctx_ff <= p1_ctx_ff;
      p2_sqx_ff <= (2*MAG_W)'(p1_ctx_ff.adx) * (2*MAG_W)'(p1_ctx_ff.adx);
      p2_sqy_ff <= (2*MAG_W)'(p1_ctx_ff.ady) * (2*MAG_W)'(p1_ctx_ff.ady);
      p2_rsq_ff <= (2*MAG_W)'(p1_ctx_ff.rsum) * (2*MAG_W)'(p1_ctx_ff.rsum);
      p3_ctx_ff <= p3_ctx_in;
      p3_sq_ff  <= p3_sq_in;
   end

   // square root, two bits of the radicand per cell
   logic              sq_vld_w  [0:SQRT_STEPS];
   logic [ROOT_W-1:0] sq_rem_w  [0:SQRT_STEPS];
   logic [ROOT_W-1:0] sq_root_w [0:SQRT_STEPS];
   logic [CTX_W-1:0]  sq_side_w [0:SQRT_STEPS];

   assign sq_vld_w[0]  = p3_vld_ff;
   assign sq_rem_w[0]  = ROOT_W'(p3_sq_ff);
   assign sq_root_w[0] = '0;
   assign sq_side_w[0] = p3_ctx_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      wcs_sqrt_cell #(
         .SQ_W   (ROOT_W),
         .SH     (2 * (SQRT_STEPS - 1 - i)),
         .SIDE_W (CTX_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .vld_i  (sq_vld_w[i]),
         .rem_i  (sq_rem_w[i]),
         .root_i (sq_root_w[i]),
         .side_i (sq_side_w[i]),
         .vld_o  (sq_vld_w[i+1]),
         .rem_o  (sq_rem_w[i+1]),
         .root_o (sq_root_w[i+1]),
         .side_o (sq_side_w[i+1])
      );
   end

   // stage 4: depth, push decision, depth times gain
   logic             p4_vld_ff;
   wcs_ctx_type      p4_ctx_ff, p4_ctx_in;
   logic [PW-1:0]    p4_prod_ff;
   logic [MAG_W-1:0] d4, depth4;
   logic [WT_W-1:0]  wt4;

   always_comb begin
      p4_ctx_in = wcs_ctx_type'(sq_side_w[SQRT_STEPS]);
      d4        = sq_root_w[SQRT_STEPS][MAG_W-1:0];
      depth4    = p4_ctx_in.rsum - d4;
      wt4       = WT_W'(p4_ctx_in.first_weight) + WT_W'(p4_ctx_in.second_weight);
      p4_ctx_in.d    = d4;
      p4_ctx_in.push = p4_ctx_in.collided &&
                       (MAG_W'(depth_threshold_ff) < depth4) &&
                       (d4 != '0) && (wt4 != '0);
   end

   // stage 5: rounded Q32.0 push magnitude
   logic             p5_vld_ff;
   wcs_ctx_type      p5_ctx_ff;
   logic [F_W-1:0]   p5_f_ff;
   logic [PW:0]      f_sum;

   assign f_sum = {1'b0, p4_prod_ff} + (PW+1)'(128);

   // stage 6: numerators for the weight shares
   logic                     p6_vld_ff;
   wcs_ctx_type              p6_ctx_ff;
   logic [1:0][N1_W-1:0]     p6_num_ff;
   logic [WT_W-1:0]          p6_wt_ff, wt6;

   assign wt6 = WT_W'(p5_ctx_ff.first_weight) + WT_W'(p5_ctx_ff.second_weight);

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
         p6_vld_ff <= 1'b0;
      end else begin
         p4_vld_ff <= sq_vld_w[SQRT_STEPS];
         p5_vld_ff <= p4_vld_ff;
         p6_vld_ff <= p5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p4_ctx_ff    <= p4_ctx_in;
      p4_prod_ff   <= PW'(depth4) * PW'(push_gain_ff);
      p5_ctx_ff    <= p4_ctx_ff;
      p5_f_ff      <= f_sum[8 +: F_W];
      p6_ctx_ff    <= p5_ctx_ff;
      p6_wt_ff     <= wt6;
      // lane 0 gives the first body's share, lane 1 the second's
      p6_num_ff[0] <= N1_W'(N1_W'(p5_f_ff) * N1_W'(p5_ctx_ff.first_weight))
                      + N1_W'(wt6 >> 1);
      p6_num_ff[1] <= N1_W'(N1_W'(p5_f_ff) * N1_W'(p5_ctx_ff.second_weight))
                      + N1_W'(wt6 >> 1);
   end

   // division by total weight, one quotient bit per cell
   logic                  d1_vld_w  [0:QB];
   logic [1:0][N1_W-1:0]  d1_num_w  [0:QB];
   logic [1:0][QB-1:0]    d1_quo_w  [0:QB];
   logic [WT_W-1:0]       d1_den_w  [0:QB];
   logic [CTX_W-1:0]      d1_side_w [0:QB];

   assign d1_vld_w[0]  = p6_vld_ff;
   assign d1_num_w[0]  = p6_num_ff;
   assign d1_quo_w[0]  = '0;
   assign d1_den_w[0]  = p6_wt_ff;
   assign d1_side_w[0] = p6_ctx_ff;

   for (genvar i = 0; i < QB; i++) begin : g_div_wt
      wcs_div_cell #(
         .LANES  (2),
         .NUM_W  (N1_W),
         .DEN_W  (WT_W),
         .QB     (QB),
         .K      (QB - 1 - i),
         .SIDE_W (CTX_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .vld_i  (d1_vld_w[i]),
         .num_i  (d1_num_w[i]),
         .quo_i  (d1_quo_w[i]),
         .den_i  (d1_den_w[i]),
         .side_i (d1_side_w[i]),
         .vld_o  (d1_vld_w[i+1]),
         .num_o  (d1_num_w[i+1]),
         .quo_o  (d1_quo_w[i+1]),
         .den_o  (d1_den_w[i+1]),
         .side_o (d1_side_w[i+1])
      );
   end

   // stage 7: share times axis distance; lanes 0,1 move the first centre
   // by the second's share, lanes 2,3 move the second by the first's share
   logic                  p7_vld_ff;
   wcs_ctx_type           p7_ctx_ff, ctx7;
   logic [3:0][PA_W-1:0]  p7_prod_ff;
   logic [F_W-1:0]        s1, s2;

   assign ctx7 = wcs_ctx_type'(d1_side_w[QB]);
   assign s1   = d1_quo_w[QB][0][F_W-1:0];
   assign s2   = d1_quo_w[QB][1][F_W-1:0];

   // stage 8: rounding term
   logic                  p8_vld_ff;
   wcs_ctx_type           p8_ctx_ff;
   logic [3:0][N2_W-1:0]  p8_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p7_vld_ff <= 1'b0;
         p8_vld_ff <= 1'b0;
      end else begin
         p7_vld_ff <= d1_vld_w[QB];
         p8_vld_ff <= p7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p7_ctx_ff     <= ctx7;
      p7_prod_ff[0] <= PA_W'(s2) * PA_W'(ctx7.adx);
      p7_prod_ff[1] <= PA_W'(s2) * PA_W'(ctx7.ady);
      p7_prod_ff[2] <= PA_W'(s1) * PA_W'(ctx7.adx);
      p7_prod_ff[3] <= PA_W'(s1) * PA_W'(ctx7.ady);
      p8_ctx_ff     <= p7_ctx_ff;
      for (int l = 0; l < 4; l++) begin
         p8_num_ff[l] <= N2_W'(p7_prod_ff[l]) + N2_W'(p7_ctx_ff.d >> 1);
      end
   end

   // division by centre distance
   logic                  d2_vld_w  [0:QB];
   logic [3:0][N2_W-1:0]  d2_num_w  [0:QB];
   logic [3:0][QB-1:0]    d2_quo_w  [0:QB];
   logic [MAG_W-1:0]      d2_den_w  [0:QB];
   logic [CTX_W-1:0]      d2_side_w [0:QB];

   assign d2_vld_w[0]  = p8_vld_ff;
   assign d2_num_w[0]  = p8_num_ff;
   assign d2_quo_w[0]  = '0;
   assign d2_den_w[0]  = p8_ctx_ff.d;
   assign d2_side_w[0] = p8_ctx_ff;

   for (genvar i = 0; i < QB; i++) begin : g_div_dist
      wcs_div_cell #(
         .LANES  (4),
         .NUM_W  (N2_W),
         .DEN_W  (MAG_W),
         .QB     (QB),
         .K      (QB - 1 - i),
         .SIDE_W (CTX_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .vld_i  (d2_vld_w[i]),
         .num_i  (d2_num_w[i]),
         .quo_i  (d2_quo_w[i]),
         .den_i  (d2_den_w[i]),
         .side_i (d2_side_w[i]),
         .vld_o  (d2_vld_w[i+1]),
         .num_o  (d2_num_w[i+1]),
         .quo_o  (d2_quo_w[i+1]),
         .den_o  (d2_den_w[i+1]),
         .side_o (d2_side_w[i+1])
      );
   end

   // output register
   logic         rsp_strobe_ff;
   wcs_rsp_type  rsp_data_ff, rsp_data_in;
   wcs_ctx_type  ctx9;

   always_comb begin
      ctx9                 = wcs_ctx_type'(d2_side_w[QB]);
      rsp_data_in.collided = ctx9.collided;
      rsp_data_in.pushed   = ctx9.push;
      if (ctx9.push) begin
         rsp_data_in.new_first_x  = sat_move(ctx9.first_x, d2_quo_w[QB][0], ctx9.neg_x);
         rsp_data_in.new_first_y  = sat_move(ctx9.first_y, d2_quo_w[QB][1], ctx9.neg_y);
         rsp_data_in.new_second_x = sat_move(ctx9.second_x, d2_quo_w[QB][2], !ctx9.neg_x);
         rsp_data_in.new_second_y = sat_move(ctx9.second_y, d2_quo_w[QB][3], !ctx9.neg_y);
      end else begin
         rsp_data_in.new_first_x  = ctx9.first_x;
         rsp_data_in.new_first_y  = ctx9.first_y;
         rsp_data_in.new_second_x = ctx9.second_x;
         rsp_data_in.new_second_y = ctx9.second_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= d2_vld_w[QB];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;
endmodule

// ===== hw/rtl/wcs_checker.sv =====
module wcs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input wcs_pkg::wcs_req_type req_data,
   input logic                 rsp_strobe,
   input wcs_pkg::wcs_rsp_type rsp_data
);
   import wcs_pkg::*;

   // every transfer in gives exactly one result, a fixed latency later
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##WCS_LATENCY rsp_strobe)
      else $error("missing result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, WCS_LATENCY))
      else $error("result without request");

   a_push_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.pushed |-> rsp_data.collided)
      else $error("push without collision");

   a_unpushed_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.pushed |->
         rsp_data.new_first_x == $past(req_data.first_x, WCS_LATENCY) &&
         rsp_data.new_second_y == $past(req_data.second_y, WCS_LATENCY))
      else $error("centre moved without push");
endmodule

bind weighted_circle_separation wcs_checker u_wcs_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import wcs_pkg::*;

   localparam longint COORD_HI = (64'sd1 <<< (COORD_BITS - 1)) - 1;
   localparam longint COORD_LO = -(64'sd1 <<< (COORD_BITS - 1));
   localparam int     REQ_W    = $bits(wcs_req_type);

   // Separation math, kept at 64 bits; magnitudes stay well inside that range.
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bit_v;
      root = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= root + bit_v) begin
            n -= root + bit_v;
            root = (root >> 1) + bit_v;
         end else begin
            root >>= 1;
         end
         bit_v >>= 2;
      end
      return root;
   endfunction

   function automatic longint shift_along(longint unsigned share, longint a,
                                          longint unsigned dist_v);
      longint unsigned mag;
      longint unsigned abs_a;
      abs_a = (a < 0) ? longint'(-a) : longint'(a);
      mag = (share * abs_a + dist_v / 2) / dist_v;
      return (a < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
      if (v > COORD_HI) v = COORD_HI;
      if (v < COORD_LO) v = COORD_LO;
      return v[COORD_BITS-1:0];
   endfunction

   class separation_board;
      logic [GAIN_BITS-1:0] gain;
      logic [THR_BITS-1:0]  thresh;
      wcs_rsp_type          pending[$];
      int                   errors;
      int                   checked;
      int                   pushes;

      function new();
         gain = GAIN_RESET;
         thresh = THR_RESET;
         errors = 0;
         checked = 0;
         pushes = 0;
      endfunction

      function void note_request(wcs_req_type r);
         longint x1, y1, x2, y2, dx, dy, nx1, ny1, nx2, ny2;
         longint unsigned adx, ady, rsum, sq, dist_v, depth, wt, f, s1, s2;
         wcs_rsp_type e;
         x1 = r.first_x; y1 = r.first_y; x2 = r.second_x; y2 = r.second_y;
         dx = x1 - x2; dy = y1 - y2;
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         rsum = longint'(r.first_radius) + longint'(r.second_radius);
         nx1 = x1; ny1 = y1; nx2 = x2; ny2 = y2;
         e.collided = 1'b0;
         e.pushed = 1'b0;
         if (adx < rsum && ady < rsum) begin
            sq = adx * adx + ady * ady;
            if (sq < rsum * rsum) begin
               dist_v = int_sqrt(sq);
               depth = rsum - dist_v;
               wt = longint'(r.first_weight) + longint'(r.second_weight);
               e.collided = 1'b1;
               if (depth > thresh && dist_v != 0 && wt != 0) begin
                  f = (depth * gain + 128) >> 8;
                  s1 = (f * r.first_weight + wt / 2) / wt;
                  s2 = (f * r.second_weight + wt / 2) / wt;
                  nx1 = x1 + shift_along(s2, dx, dist_v);
                  ny1 = y1 + shift_along(s2, dy, dist_v);
                  nx2 = x2 - shift_along(s1, dx, dist_v);
                  ny2 = y2 - shift_along(s1, dy, dist_v);
                  e.pushed = 1'b1;
               end
            end
         end
         e.new_first_x = clamp_coord(nx1);
         e.new_first_y = clamp_coord(ny1);
         e.new_second_x = clamp_coord(nx2);
         e.new_second_y = clamp_coord(ny2);
         pending.push_back(e);
      endfunction

      function void check_result(wcs_rsp_type a);
         wcs_rsp_type e;
         if (pending.size() == 0) begin
            $error("result with nothing outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (e.pushed) pushes++;
         if (a.collided !== e.collided) begin
            $error("collided exp %0d got %0d", e.collided, a.collided); errors++;
         end
         if (a.pushed !== e.pushed) begin
            $error("pushed exp %0d got %0d", e.pushed, a.pushed); errors++;
         end
         if (a.new_first_x !== e.new_first_x) begin
            $error("new_first_x exp %0d got %0d", e.new_first_x, a.new_first_x);
            errors++;
         end
         if (a.new_first_y !== e.new_first_y) begin
            $error("new_first_y exp %0d got %0d", e.new_first_y, a.new_first_y);
            errors++;
         end
         if (a.new_second_x !== e.new_second_x) begin
            $error("new_second_x exp %0d got %0d", e.new_second_x, a.new_second_x);
            errors++;
         end
         if (a.new_second_y !== e.new_second_y) begin
            $error("new_second_y exp %0d got %0d", e.new_second_y, a.new_second_y);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   wcs_req_type           req_data;
   logic                  rsp_strobe;
   wcs_rsp_type           rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_addr;
   logic [CSR_W-1:0]      csr_wdata;

   separation_board board;
   int              burst_left;

   weighted_circle_separation u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         board.check_result(rsp_data);
      end
   end

   // One transfer; at the end of each burst a gap of random length, sometimes none, follows.
   task automatic send_pair(wcs_req_type r);
      int gap;
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(r);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic finish_sending();
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PUSH_GAIN) board.gain = val[GAIN_BITS-1:0];
      else board.thresh = val[THR_BITS-1:0];
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (WCS_LATENCY + 10) @(posedge clock);
   endtask

   // Mostly overlapping pairs near a random anchor so the push path gets exercised.
   function automatic wcs_req_type rand_pair();
      wcs_req_type r;
      int          span;
      r = REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom()});
      case ($urandom_range(0, 9))
         0, 1: ;
         default: begin
            span = 1 << $urandom_range(4, 20);
            r.second_x = COORD_BITS'(r.first_x + $signed($urandom_range(0, 2 * span))
                                     - span);
            r.second_y = COORD_BITS'(r.first_y + $signed($urandom_range(0, 2 * span))
                                     - span);
            r.first_radius = RAD_BITS'($urandom_range(0, 2 * span));
            r.second_radius = RAD_BITS'($urandom_range(0, 2 * span));
            if ($urandom_range(0, 3) != 0) begin
               r.first_weight = WGT_BITS'($urandom_range(0, 300));
               r.second_weight = WGT_BITS'($urandom_range(0, 300));
            end
            if ($urandom_range(0, 15) == 0) r.first_weight = '0;
            if ($urandom_range(0, 15) == 0) r.second_weight = '0;
            if ($urandom_range(0, 31) == 0) begin
               r.second_x = r.first_x;
               r.second_y = r.first_y;
            end
         end
      endcase
      return r;
   endfunction

   function automatic wcs_req_type make_pair(longint x1, longint y1, longint r1,
                                             longint w1, longint x2, longint y2,
                                             longint r2, longint w2);
      wcs_req_type r;
      r.first_x = COORD_BITS'(x1); r.first_y = COORD_BITS'(y1);
      r.first_radius = RAD_BITS'(r1); r.first_weight = WGT_BITS'(w1);
      r.second_x = COORD_BITS'(x2); r.second_y = COORD_BITS'(y2);
      r.second_radius = RAD_BITS'(r2); r.second_weight = WGT_BITS'(w2);
      return r;
   endfunction

   task automatic random_phase(int count);
      repeat (count) send_pair(rand_pair());
      finish_sending();
      drain();
   endtask

   initial begin
      board = new();
      burst_left = 5;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_addr = CSR_PUSH_GAIN;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset registers
      send_pair(make_pair(0, 0, 256, 1, 512, 0, 512, 1));
      send_pair(make_pair(0, 0, 0, 5, 0, 0, 0, 5));                // zero radii
      send_pair(make_pair(100, 100, 500, 3, 100, 100, 500, 4));    // coincident
      send_pair(make_pair(0, 0, 4000, 0, 300, 400, 4000, 0));      // zero weight
      send_pair(make_pair(0, 0, 100, 1, 1000, 1000, 100, 1));      // apart
      send_pair(make_pair(0, 0, 400, 1, 0, 600, 300, 1));          // shallow
      send_pair(make_pair(COORD_HI, COORD_LO, 8388607, 65535,
                          COORD_HI - 10, COORD_LO + 10, 8388607, 65535));
      send_pair(make_pair(COORD_LO, COORD_HI, 8388607, 1,
                          COORD_LO + 1000, COORD_HI - 7, 8388607, 65535));
      send_pair(make_pair(-300, 200, 8388607, 65535, 300, -200, 8388607, 0));
      send_pair(make_pair(COORD_HI, COORD_HI, 8388607, 65535,
                          COORD_LO, COORD_LO, 8388607, 65535));
      send_pair(make_pair(-1, -1, 1, 7, 0, 0, 1, 9));
      finish_sending();
      drain();

      write_reg(CSR_PUSH_GAIN, CSR_W'(16'hFFFF));
      write_reg(CSR_DEPTH_THRESHOLD, 23'd0);
      send_pair(make_pair(0, 0, 8388607, 65535, 5, -3, 8388607, 1));
      send_pair(make_pair(10, 10, 1, 2, 10, 11, 1, 3));
      send_pair(make_pair(COORD_LO, 0, 8388607, 1, COORD_LO + 2, 1, 8388607, 1));
      finish_sending();
      drain();
      random_phase(400);

      write_reg(CSR_PUSH_GAIN, CSR_W'(16'd0));
      write_reg(CSR_DEPTH_THRESHOLD, 23'h7FFFFF);
      send_pair(make_pair(0, 0, 8388607, 9, 50, 50, 8388607, 9));
      finish_sending();
      drain();
      random_phase(250);

      write_reg(CSR_DEPTH_THRESHOLD, 23'd0);
      random_phase(200);

      write_reg(CSR_PUSH_GAIN, CSR_W'($urandom_range(0, 65535)));
      write_reg(CSR_DEPTH_THRESHOLD, CSR_W'($urandom_range(0, 4096)));
      random_phase(450);

      write_reg(CSR_PUSH_GAIN, CSR_W'(GAIN_RESET));
      write_reg(CSR_DEPTH_THRESHOLD, THR_RESET);
      random_phase(400);

      $display("checked %0d transfers over 5 register settings, %0d with a push",
               board.checked, board.pushes);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("weighted_circle_separation verification clean");
      end else begin
         $display("weighted_circle_separation verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("weighted_circle_separation verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/wcs_pkg.sv
hw/rtl/wcs_sqrt_cell.sv
hw/rtl/wcs_div_cell.sv
hw/rtl/weighted_circle_separation.sv
hw/rtl/wcs_checker.sv
dv/tb_top.sv
